/* design/stbq_pkg.sv */
`timescale 1ns / 1ps

package stbq_pkg;

	localparam int SAMPLE_W  = 24;
	localparam int CFG_W     = 63;
	localparam int CFG_IDX_W = 3;
	localparam int CTRL_W    = 6;
	localparam int NUM_BANDS = 4;
	localparam int NUM_TERMS = 5;
	localparam int NUM_COEF_REGS = 7;
	localparam int SLOTS     = 3;
	localparam int BAND_W    = 2;
	localparam int TERM_W    = 3;
	localparam int STEP_W    = 3;
	localparam int HIST_DEPTH = 32;
	localparam int HIST_AW   = 5;

	localparam logic [CFG_IDX_W-1:0] REG_CONTROL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF0   = 3'd1;

	localparam logic [CTRL_W-1:0] CTRL_RESET = 6'd32;
	localparam int CTRL_BYPASS = 0;
	localparam int CTRL_BAND0  = 1;
	localparam int CTRL_STEREO = 5;

	// history word order inside one band
	localparam logic [1:0] TAP_X1 = 2'd0;
	localparam logic [1:0] TAP_X2 = 2'd1;
	localparam logic [1:0] TAP_Y1 = 2'd2;
	localparam logic [1:0] TAP_Y2 = 2'd3;

	localparam logic [BAND_W-1:0] BAND_LAST = 2'd3;
	localparam logic [STEP_W-1:0] STEP_LAST = 3'd6;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_in;
		logic signed [SAMPLE_W-1:0] right_in;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_out;
		logic signed [SAMPLE_W-1:0] right_out;
	} out_item_t;

	typedef struct packed {
		logic go;
		logic first;
		logic sub;
	} mac_ctl_t;

	typedef struct packed {
		logic [BAND_W-1:0] band;
		logic [TERM_W-1:0] term;
	} coef_sel_t;

endpackage

/* design/stereo_four_band_biquad_cascade_core.sv */
`timescale 1ns / 1ps

// Stereo four-band biquad equalizer.
// Input channel: in_valid/in_ready carry one left/right sample pair per
// transfer. Output channel: out_valid/out_ready carry the filtered pair.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index
// (0 control, 1..7 coefficient banks); write only while idle.
// Each enabled band of each channel passes the scan state and then runs seven
// steps on the single shared multiplier; a disabled band is only scanned,
// and each filtered channel ends in a finish state that saturates it. In
// bypass, or with no band enabled, the accepted pair goes straight to the
// done state and on to the output register.
// in_ready is high only while no sample pair is being filtered.
// A finished pair sits in the output register, so the next pair is accepted
// while the receiver stalls; the block only holds when a second result is
// ready and the output register is still full.
// Reset clears all filter history (read as zero until first written), all
// coefficients, and sets control to stereo with every band disabled.
module stereo_four_band_biquad_cascade_core import stbq_pkg::*; #(
	parameter int COEF_BITS    = 21,
	parameter int HISTORY_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data
);

	logic [CTRL_W-1:0]                         control_q;
	logic [NUM_COEF_REGS-1:0][CFG_W-1:0]       bank_q;
	logic signed [COEF_BITS-1:0]               coef_w [NUM_BANDS][NUM_TERMS];
	logic signed [COEF_BITS-1:0]               coef;
	coef_sel_t                                 coef_sel;
	mac_ctl_t                                  mac_ctl;
	logic signed [HISTORY_BITS-1:0]            mac_b;
	logic signed [HISTORY_BITS-1:0]            mac_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q <= CTRL_RESET;
			bank_q    <= '0;
		end else if (cfg_wr_en) begin
			if (cfg_index == REG_CONTROL) begin
				control_q <= cfg_data[CTRL_W-1:0];
			end else begin
				bank_q[3'(cfg_index - REG_COEF0)] <= cfg_data;
			end
		end
	end

	// coefficients are packed three to a bank in band order b0 b1 b2 a1 a2
	for (genvar b = 0; b < NUM_BANDS; b++) begin : g_band
		for (genvar t = 0; t < NUM_TERMS; t++) begin : g_term
			localparam int N = b * NUM_TERMS + t;
			assign coef_w[b][t] = bank_q[N / SLOTS][(N % SLOTS) * COEF_BITS +: COEF_BITS];
		end
	end

	assign coef = coef_w[coef_sel.band][coef_sel.term];

	stbq_mac #(
		.COEF_BITS   (COEF_BITS),
		.HISTORY_BITS(HISTORY_BITS)
	) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (mac_ctl),
		.a     (coef),
		.b     (mac_b),
		.y     (mac_y)
	);

	stbq_seq #(
		.HISTORY_BITS(HISTORY_BITS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.control  (control_q),
		.coef_sel (coef_sel),
		.mac_ctl  (mac_ctl),
		.mac_b    (mac_b),
		.mac_y    (mac_y)
	);

endmodule

/* design/stbq_ram.sv */
`timescale 1ns / 1ps

module stbq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* design/stbq_mac.sv */
`timescale 1ns / 1ps

module stbq_mac import stbq_pkg::*; #(
	parameter int COEF_BITS    = 21,
	parameter int HISTORY_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mac_ctl_t                       ctl,
	input  logic signed [COEF_BITS-1:0]    a,
	input  logic signed [HISTORY_BITS-1:0] b,
	output logic signed [HISTORY_BITS-1:0] y
);

	localparam int PROD_W = COEF_BITS + HISTORY_BITS;
	localparam int ACC_W  = PROD_W + 3;
	localparam int FRAC   = COEF_BITS - 4;
	localparam int SH_W   = ACC_W - FRAC;
	localparam logic [ACC_W-1:0] HALF = {{(ACC_W-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};

	logic signed [PROD_W-1:0] prod_s1;
	mac_ctl_t                 ctl_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  prod_x;
	logic signed [ACC_W-1:0]  acc_base;
	logic signed [ACC_W-1:0]  rnd;
	logic signed [SH_W-1:0]   sh;

	assign prod_x   = ACC_W'(prod_s1);
	assign acc_base = ctl_s1.first ? '0 : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1  <= ctl;
			prod_s1 <= a * b;
			if (ctl_s1.go) begin
				acc_q <= ctl_s1.sub ? acc_base - prod_x : acc_base + prod_x;
			end
		end
	end

	// round half up, then clamp to the history word
	always_comb begin
		rnd = acc_q + HALF;
		sh  = rnd[ACC_W-1:FRAC];
		if (sh[SH_W-1:HISTORY_BITS-1] == '0 || sh[SH_W-1:HISTORY_BITS-1] == '1) begin
			y = sh[HISTORY_BITS-1:0];
		end else if (sh[SH_W-1]) begin
			y = {1'b1, {(HISTORY_BITS-1){1'b0}}};
		end else begin
			y = {1'b0, {(HISTORY_BITS-1){1'b1}}};
		end
	end

endmodule

/* design/stbq_seq.sv */
`timescale 1ns / 1ps

module stbq_seq import stbq_pkg::*; #(
	parameter int HISTORY_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  in_item_t                       in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output out_item_t                      out_data,
	input  logic [CTRL_W-1:0]              control,
	output coef_sel_t                      coef_sel,
	output mac_ctl_t                       mac_ctl,
	output logic signed [HISTORY_BITS-1:0] mac_b,
	input  logic signed [HISTORY_BITS-1:0] mac_y
);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_RUN, S_FIN, S_DONE} state_t;

	state_t                         state_q;
	logic                           ch_q;
	logic [BAND_W-1:0]              band_q;
	logic [STEP_W-1:0]              step_q;
	logic signed [HISTORY_BITS-1:0] x_q;
	logic signed [HISTORY_BITS-1:0] h0_q;
	logic signed [HISTORY_BITS-1:0] h2_q;
	in_item_t                       in_q;
	out_item_t                      res_q;
	out_item_t                      out_q;
	logic                           out_valid_q;

	logic [HIST_DEPTH-1:0]          valid_q;
	logic                           rd_valid_q;
	logic                           hist_we;
	logic                           hist_re;
	logic [HIST_AW-1:0]             hist_waddr;
	logic [HIST_AW-1:0]             hist_raddr;
	logic [HISTORY_BITS-1:0]        hist_wdata;
	logic [HISTORY_BITS-1:0]        hist_rdata;
	logic signed [HISTORY_BITS-1:0] hist_rd;

	logic [NUM_BANDS-1:0]           band_en;
	logic                           active;
	logic signed [SAMPLE_W-1:0]     x_sat;

	assign band_en   = control[CTRL_BAND0 +: NUM_BANDS];
	assign active    = !control[CTRL_BYPASS] && (band_en != '0);
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// never-written history reads as zero
	assign hist_rd = rd_valid_q ? signed'(hist_rdata) : '0;

	always_comb begin
		if (x_q[HISTORY_BITS-1:SAMPLE_W-1] == '0 || x_q[HISTORY_BITS-1:SAMPLE_W-1] == '1) begin
			x_sat = x_q[SAMPLE_W-1:0];
		end else if (x_q[HISTORY_BITS-1]) begin
			x_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			x_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

	// band step schedule: multiply on steps 0-4 while reads stream in,
	// retire old taps as soon as their reads are done, write y1 last
	always_comb begin
		hist_re       = 1'b0;
		hist_raddr    = {ch_q, band_q, step_q[1:0]};
		hist_we       = 1'b0;
		hist_waddr    = {ch_q, band_q, TAP_X1};
		hist_wdata    = x_q;
		mac_ctl       = '0;
		coef_sel.band = band_q;
		coef_sel.term = '0;
		mac_b         = (step_q == '0) ? x_q : hist_rd;
		if (state_q == S_RUN) begin
			unique case (step_q)
				3'd0: begin
					hist_re       = 1'b1;
					mac_ctl.go    = 1'b1;
					mac_ctl.first = 1'b1;
				end
				3'd1: begin
					hist_re       = 1'b1;
					mac_ctl.go    = 1'b1;
					coef_sel.term = step_q;
				end
				3'd2: begin
					hist_re       = 1'b1;
					mac_ctl.go    = 1'b1;
					coef_sel.term = step_q;
					hist_we       = 1'b1;
					hist_waddr    = {ch_q, band_q, TAP_X2};
					hist_wdata    = h0_q;
				end
				3'd3: begin
					hist_re       = 1'b1;
					mac_ctl.go    = 1'b1;
					mac_ctl.sub   = 1'b1;
					coef_sel.term = step_q;
					hist_we       = 1'b1;
					hist_waddr    = {ch_q, band_q, TAP_X1};
					hist_wdata    = x_q;
				end
				3'd4: begin
					mac_ctl.go    = 1'b1;
					mac_ctl.sub   = 1'b1;
					coef_sel.term = step_q;
					hist_we       = 1'b1;
					hist_waddr    = {ch_q, band_q, TAP_Y2};
					hist_wdata    = h2_q;
				end
				3'd6: begin
					hist_we       = 1'b1;
					hist_waddr    = {ch_q, band_q, TAP_Y1};
					hist_wdata    = mac_y;
				end
				default: begin
				end
			endcase
		end
	end

	stbq_ram #(
		.WIDTH(HISTORY_BITS),
		.DEPTH(HIST_DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (hist_we),
		.waddr(hist_waddr),
		.wdata(hist_wdata),
		.re   (hist_re),
		.raddr(hist_raddr),
		.rdata(hist_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (hist_we) begin
				valid_q[hist_waddr] <= 1'b1;
			end
			if (hist_re) begin
				rd_valid_q <= valid_q[hist_raddr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ch_q        <= 1'b0;
			band_q      <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// drop valid after a transfer unless a new result loads this cycle
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						in_q   <= in_data;
						ch_q   <= 1'b0;
						band_q <= '0;
						x_q    <= HISTORY_BITS'(in_data.left_in);
						if (active) begin
							state_q <= S_SCAN;
						end else begin
							res_q.left_out  <= in_data.left_in;
							res_q.right_out <= in_data.right_in;
							state_q         <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					if (band_en[band_q]) begin
						step_q  <= '0;
						state_q <= S_RUN;
					end else if (band_q == BAND_LAST) begin
						state_q <= S_FIN;
					end else begin
						band_q <= band_q + 2'd1;
					end
				end
				S_RUN: begin
					if (step_q == 3'd1) begin
						h0_q <= hist_rd;
					end
					if (step_q == 3'd3) begin
						h2_q <= hist_rd;
					end
					if (step_q == STEP_LAST) begin
						x_q <= mac_y;
						if (band_q == BAND_LAST) begin
							state_q <= S_FIN;
						end else begin
							band_q  <= band_q + 2'd1;
							state_q <= S_SCAN;
						end
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				S_FIN: begin
					if (!ch_q) begin
						res_q.left_out <= x_sat;
						if (control[CTRL_STEREO]) begin
							ch_q    <= 1'b1;
							band_q  <= '0;
							x_q     <= HISTORY_BITS'(in_q.right_in);
							state_q <= S_SCAN;
						end else begin
							res_q.right_out <= in_q.right_in;
							state_q         <= S_DONE;
						end
					end else begin
						res_q.right_out <= x_sat;
						state_q         <= S_DONE;
					end
				end
				S_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_bypass_skips: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !active) |=> state_q == S_DONE)
		else $error("inactive item entered the filter path");

	a_mono_right_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(hist_we && !control[CTRL_STEREO]) |-> !hist_waddr[HIST_AW-1])
		else $error("right history written in mono");

	a_run_band_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> band_en[band_q])
		else $error("disabled band being filtered");

	a_run_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN && step_q == STEP_LAST) |=> state_q == S_SCAN || state_q == S_FIN)
		else $error("band sequence did not end after last step");

endmodule

/* test/stereo_four_band_biquad_cascade_core_tb.sv */
`timescale 1ns / 1ps

module stereo_four_band_biquad_cascade_core_tb;
	import stbq_pkg::*;

	localparam int COEF_W       = 21;
	localparam int FRAC_W       = COEF_W - 4;
	localparam int HIST_W       = 32;
	localparam int PLAN_SLOTS   = SLOTS * NUM_COEF_REGS;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 80;
	localparam int RANDOM_PAIRS = 830;
	localparam int PRINT_LIMIT  = 40;

	localparam logic [COEF_W-1:0] COEF_ONE = 21'h020000;
	localparam logic [COEF_W-1:0] COEF_MAX = 21'h0FFFFF;
	localparam logic [COEF_W-1:0] COEF_MIN = 21'h100000;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

	localparam logic [CTRL_W-1:0] CTL_BYPASS_M = 6'(1) << CTRL_BYPASS;
	localparam logic [CTRL_W-1:0] CTL_STEREO_M = 6'(1) << CTRL_STEREO;
	localparam logic [CTRL_W-1:0] CTL_BANDS_M  = 6'(4'hF) << CTRL_BAND0;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_CONTROL;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_item_t             in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_data;

	// equalizer state as the block should hold it
	logic [CTRL_W-1:0] eq_control;
	logic [CFG_W-1:0]  eq_banks [NUM_COEF_REGS];
	longint            eq_history [HIST_DEPTH];

	out_item_t         expected_pairs [$];
	out_item_t         next_expected;
	logic [COEF_W-1:0] coef_plan [PLAN_SLOTS];
	bit                steady_flow = 1'b0;
	int                error_count = 0;
	int                results_seen = 0;
	int                cycle_count = 0;

	stereo_four_band_biquad_cascade_core #(
		.COEF_BITS   (COEF_W),
		.HISTORY_BITS(HIST_W)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count == CYCLE_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	always @(posedge clk) begin
		out_ready <= steady_flow || ($urandom_range(99) >= 14);
	end

	function automatic longint clamp(longint v, int w);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	function automatic longint coef_value(int n);
		logic [CFG_W-1:0]         bank;
		logic signed [COEF_W-1:0] c;
		bank = eq_banks[n / SLOTS];
		c = bank[(n % SLOTS) * COEF_W +: COEF_W];
		return longint'(c);
	endfunction

	// run one channel through the enabled bands, updating its history
	function automatic longint run_band_chain(int ch, longint x);
		longint acc;
		longint y;
		int     h;
		int     c;
		for (int b = 0; b < NUM_BANDS; b++) begin
			if (eq_control[CTRL_BAND0 + b]) begin
				h = ch * NUM_BANDS * 4 + b * 4;
				c = b * NUM_TERMS;
				acc = coef_value(c) * x
					+ coef_value(c + 1) * eq_history[h + TAP_X1]
					+ coef_value(c + 2) * eq_history[h + TAP_X2]
					- coef_value(c + 3) * eq_history[h + TAP_Y1]
					- coef_value(c + 4) * eq_history[h + TAP_Y2];
				// round half up, then clip to the history word
				y = clamp((acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W, HIST_W);
				eq_history[h + TAP_X2] = eq_history[h + TAP_X1];
				eq_history[h + TAP_X1] = x;
				eq_history[h + TAP_Y2] = eq_history[h + TAP_Y1];
				eq_history[h + TAP_Y1] = y;
				x = y;
			end
		end
		return clamp(x, SAMPLE_W);
	endfunction

	function automatic out_item_t predict_pair(in_item_t pair);
		out_item_t res;
		longint    l;
		longint    r;
		l = longint'(pair.left_in);
		r = longint'(pair.right_in);
		if (!eq_control[CTRL_BYPASS] && eq_control[CTRL_BAND0 +: NUM_BANDS] != '0) begin
			l = run_band_chain(0, l);
			if (eq_control[CTRL_STEREO])
				r = run_band_chain(1, r);
		end
		res.left_out = SAMPLE_W'(l);
		res.right_out = SAMPLE_W'(r);
		return res;
	endfunction

	function automatic logic [COEF_W-1:0] jitter(int center, int span);
		return COEF_W'(center + int'($urandom_range(2 * span)) - span);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(9))
			0, 1, 2, 3: return SAMPLE_W'($urandom);
			4, 5:       return SAMPLE_W'(int'($urandom_range(8191)) - 4096);
			6: begin
				case ($urandom_range(3))
					0: return SAMPLE_MAX;
					1: return SAMPLE_MIN;
					2: return '0;
					default: return '1;
				endcase
			end
			default:    return SAMPLE_W'(int'($urandom_range(2097151)) - 1048576);
		endcase
	endfunction

	function automatic in_item_t make_pair(logic signed [SAMPLE_W-1:0] l,
		logic signed [SAMPLE_W-1:0] r);
		in_item_t p;
		p.left_in = l;
		p.right_in = r;
		return p;
	endfunction

	task automatic report_mismatch(string msg);
		if (error_count < PRINT_LIMIT)
			$display("mismatch at result %0d: %s", results_seen, msg);
		error_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_pairs.size() == 0) begin
				report_mismatch($sformatf("unexpected result left %0d right %0d",
					out_data.left_out, out_data.right_out));
			end else begin
				next_expected = expected_pairs.pop_front();
				if (out_data.left_out !== next_expected.left_out)
					report_mismatch($sformatf("left_out got %0d expected %0d",
						out_data.left_out, next_expected.left_out));
				if (out_data.right_out !== next_expected.right_out)
					report_mismatch($sformatf("right_out got %0d expected %0d",
						out_data.right_out, next_expected.right_out));
			end
			results_seen++;
		end
	end

	// leaves the write enable high so back-to-back writes need no gap
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		if (idx == REG_CONTROL)
			eq_control = data[CTRL_W-1:0];
		else
			eq_banks[idx - REG_COEF0] = data;
	endtask

	task automatic close_writes();
		cfg_wr_en <= 1'b0;
		cfg_index <= CFG_IDX_W'($urandom);
		cfg_data <= CFG_W'({$urandom, $urandom});
		@(posedge clk);
	endtask

	task automatic write_control(logic [CTRL_W-1:0] ctl);
		// upper data bits are junk the block must drop
		write_reg(REG_CONTROL, {(CFG_W - CTRL_W)'({$urandom, $urandom}), ctl});
	endtask

	task automatic write_coef_banks();
		coef_plan[PLAN_SLOTS - 1] = COEF_W'($urandom);
		for (int i = 0; i < NUM_COEF_REGS; i++) begin
			write_reg(CFG_IDX_W'(REG_COEF0 + i),
				{coef_plan[i * SLOTS + 2], coef_plan[i * SLOTS + 1], coef_plan[i * SLOTS]});
		end
	endtask

	task automatic send_pair(in_item_t pair);
		if (!steady_flow && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			in_data <= make_pair(SAMPLE_W'($urandom), SAMPLE_W'($urandom));
			do @(posedge clk); while ($urandom_range(99) < 60);
		end
		in_valid <= 1'b1;
		in_data <= pair;
		do @(posedge clk); while (!in_ready);
		expected_pairs.push_back(predict_pair(pair));
	endtask

	// drop valid and wait until every transfer has come back
	task automatic finish_phase();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_pairs.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_unity_coefs();
		for (int n = 0; n < PLAN_SLOTS; n++)
			coef_plan[n] = (n % NUM_TERMS == 0 && n < NUM_BANDS * NUM_TERMS) ? COEF_ONE : '0;
	endtask

	task automatic plan_random_coefs();
		int style;
		style = $urandom_range(3);
		for (int n = 0; n < NUM_BANDS * NUM_TERMS; n++) begin
			case (style)
				0: coef_plan[n] = (n % NUM_TERMS == 0) ? jitter(131072, 16384)
					: jitter(0, 24576);
				1: coef_plan[n] = COEF_W'($urandom);
				default: begin
					// resonant but stable sections: a1 near -1.8, a2 near 0.85
					case (n % NUM_TERMS)
						0: coef_plan[n] = jitter(131072, 8192);
						1: coef_plan[n] = jitter(-235930, 4096);
						2: coef_plan[n] = jitter(111411, 4096);
						3: coef_plan[n] = jitter(-235930, 2048);
						default: coef_plan[n] = jitter(111411, 2048);
					endcase
				end
			endcase
		end
	endtask

	// reset values: stereo, no band enabled, so samples pass straight through
	task automatic test_no_band_passthrough();
		send_pair(make_pair(SAMPLE_MAX, SAMPLE_MIN));
		send_pair(make_pair(SAMPLE_MIN, SAMPLE_MAX));
		send_pair(make_pair('0, '1));
		send_pair(make_pair(24'sd1, '0));
		finish_phase();
	endtask

	task automatic test_unity_cascade();
		set_unity_coefs();
		write_coef_banks();
		write_control(CTL_BANDS_M | CTL_STEREO_M);
		close_writes();
		send_pair(make_pair(SAMPLE_MAX, SAMPLE_MIN));
		send_pair(make_pair(24'sd12345, -24'sd54321));
		finish_phase();
	endtask

	// b0 of one LSB puts the product right on the rounding boundary
	task automatic test_rounding();
		for (int n = 0; n < PLAN_SLOTS; n++)
			coef_plan[n] = '0;
		coef_plan[0] = 21'd1;
		write_coef_banks();
		write_control((6'(1) << CTRL_BAND0) | CTL_STEREO_M);
		close_writes();
		send_pair(make_pair(24'sd65536, -24'sd65536));
		send_pair(make_pair(24'sd65535, -24'sd65535));
		send_pair(make_pair(24'sd196608, -24'sd196608));
		finish_phase();
	endtask

	task automatic test_extreme_coefs();
		for (int n = 0; n < PLAN_SLOTS; n++)
			coef_plan[n] = (n % NUM_TERMS < 3) ? COEF_MAX : COEF_MIN;
		write_coef_banks();
		write_control(CTL_BANDS_M | CTL_STEREO_M);
		close_writes();
		send_pair(make_pair(SAMPLE_MAX, SAMPLE_MIN));
		send_pair(make_pair(SAMPLE_MAX, SAMPLE_MAX));
		send_pair(make_pair(SAMPLE_MIN, SAMPLE_MIN));
		send_pair(make_pair('0, '0));
		finish_phase();
		for (int n = 0; n < PLAN_SLOTS; n++)
			coef_plan[n] = COEF_MIN;
		write_coef_banks();
		close_writes();
		send_pair(make_pair(SAMPLE_MIN, SAMPLE_MAX));
		send_pair(make_pair(24'sd1, -24'sd1));
		send_pair(make_pair('0, '0));
		finish_phase();
	endtask

	task automatic test_bypass_and_mono();
		set_unity_coefs();
		coef_plan[3] = COEF_MIN;
		write_coef_banks();
		write_control(CTL_BYPASS_M | CTL_BANDS_M | CTL_STEREO_M);
		close_writes();
		send_pair(make_pair(SAMPLE_MAX, SAMPLE_MIN));
		send_pair(make_pair(-24'sd777, 24'sd999));
		finish_phase();
		write_control(CTL_BANDS_M);
		close_writes();
		send_pair(make_pair(24'sd4096, SAMPLE_MAX));
		send_pair(make_pair(-24'sd300000, SAMPLE_MIN));
		send_pair(make_pair(SAMPLE_MAX, 24'sd5));
		finish_phase();
	endtask

	task automatic test_random_phases();
		int               sent;
		int               phase;
		int               span;
		logic [CTRL_W-1:0] ctl;
		sent = 0;
		phase = 0;
		while (sent < RANDOM_PAIRS) begin
			if ($urandom_range(3) != 0) begin
				plan_random_coefs();
				write_coef_banks();
			end
			case ($urandom_range(9))
				0, 1: ctl = CTRL_W'($urandom);
				2:    ctl = (6'(1) << (CTRL_BAND0 + $urandom_range(NUM_BANDS - 1)))
					| (CTRL_W'($urandom_range(1)) << CTRL_STEREO);
				default: begin
					ctl = CTRL_W'($urandom) & (CTL_BANDS_M | CTL_STEREO_M);
					if ((ctl & CTL_BANDS_M) == '0)
						ctl = ctl | CTL_BANDS_M;
				end
			endcase
			write_control(ctl);
			close_writes();
			steady_flow = (phase == 6);
			span = $urandom_range(8, 48);
			for (int i = 0; i < span; i++)
				send_pair(make_pair(pick_sample(), pick_sample()));
			sent += span;
			finish_phase();
			phase++;
		end
		steady_flow = 1'b0;
	endtask

	initial begin
		eq_control = CTRL_RESET;
		for (int i = 0; i < NUM_COEF_REGS; i++)
			eq_banks[i] = '0;
		for (int i = 0; i < HIST_DEPTH; i++)
			eq_history[i] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_no_band_passthrough();
		test_unity_cascade();
		test_rounding();
		test_extreme_coefs();
		test_bypass_and_mono();
		test_random_phases();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
